// ===== src/mwo_pkg.sv =====
// ============================================================================
// Multi-waveform oscillator package
// Shared widths, register indexes, waveform codes and helper functions.
// ============================================================================
`default_nettype none

package mwo_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;

    localparam int FREQ_W    = 32;
    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int WAVE_W    = 3;

    localparam int QTAB_N    = 1 << SINE_TABLE_BITS;
    localparam int TAB_DEPTH = QTAB_N + 1;
    localparam int TAB_AW    = SINE_TABLE_BITS + 1;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_PER_HZ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM     = 2'd1;

    localparam logic [CFG_W-1:0] PHASE_PER_HZ_RESET = 32'd22906492;

    localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd0;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_SAW_DOWN = 3'd2;
    localparam logic [WAVE_W-1:0] WAVE_SAW_UP   = 3'd3;
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd4;

    localparam logic [PHASE_BITS-1:0] HALF_PHASE = {1'b1, {(PHASE_BITS-1){1'b0}}};

    typedef struct packed {
        logic                we;
        logic [TAB_AW-1:0]   addr;
        logic [SAMPLE_W-1:0] data;
    } tab_wr_t;

    // Top 32 bits of the phase, padded with zeros below when the phase is narrower.
    function automatic logic [31:0] phase_to_32(input logic [PHASE_BITS-1:0] ph);
        logic [PHASE_BITS+31:0] ext;
        ext = {ph, 32'd0};
        return ext[PHASE_BITS+31 -: 32];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [18:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 19'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -19'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/multi_waveform_oscillator_unit.sv =====
// ============================================================================
// Multi-waveform numerically controlled oscillator
// Phase accumulator with sine, square, saw and triangle outputs; one sample
// per frequency beat, taken from the phase before it advances.
// ============================================================================
//
//  Channel   Ports                        Beat
//  input     s_valid s_ready s_freq       signed Q24.8 frequency in Hz
//  result    m_valid m_ready m_sample     signed Q1.15 sample
//  config    cfg_wr_en cfg_index ...      register write, no handshake
//
// One beat per cycle is sustained while m_ready is high; each frequency beat passes
// through the registered increment multiply, phase update with table RAM read, and shaping.
// After reset the sine table is built into its RAM, 2^SINE_TABLE_BITS + 1 entries
// in all, with s_ready low throughout. A stalled result holds the pipeline; empty
// stages still fill, so up to three beats are taken while m_ready is low.
`default_nettype none

module multi_waveform_oscillator_unit
    import mwo_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [FREQ_W-1:0]   s_freq,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_wr_data
);

    logic [CFG_W-1:0]            phase_per_hz_reg, phase_per_hz_next;
    logic [WAVE_W-1:0]           waveform_reg, waveform_next;
    logic [PHASE_BITS-1:0]       phase_reg, phase_next;
    logic                        v1_reg, v1_next;
    logic [PHASE_BITS-1:0]       inc1_reg, inc1_next;
    logic                        v2_reg, v2_next;
    logic [PHASE_BITS-1:0]       ph2_reg, ph2_next;
    logic                        m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0]  m_sample_reg, m_sample_next;

    logic                        en1, en2, en3;
    logic signed [64:0]          prod_w;
    logic [31:0]                 p_cur, p_out;
    logic [SINE_TABLE_BITS-1:0]  idx;
    logic [TAB_AW-1:0]           tab_rd_addr;
    logic [SAMPLE_W-1:0]         tab_rd_data;
    logic                        first_half;
    logic signed [18:0]          wave_wide;
    logic                        init_done;
    tab_wr_t                     tab_wr;

    mwo_sine_init u_init (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tab_wr    (tab_wr),
        .init_done (init_done)
    );

    mwo_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAB_DEPTH)
    ) u_tab (
        .aclk    (aclk),
        .wr_en   (tab_wr.we),
        .wr_addr (tab_wr.addr),
        .wr_data (tab_wr.data),
        .rd_en   (en2),
        .rd_addr (tab_rd_addr),
        .rd_data (tab_rd_data)
    );

    assign en3     = !m_valid_reg || m_ready;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1 && init_done;

    assign prod_w = s_freq * $signed({1'b0, phase_per_hz_reg});

    assign p_cur       = phase_to_32(phase_reg);
    assign idx         = p_cur[29 -: SINE_TABLE_BITS];
    assign tab_rd_addr = p_cur[30] ? TAB_AW'(QTAB_N) - {1'b0, idx} : {1'b0, idx};

    assign p_out      = phase_to_32(ph2_reg);
    assign first_half = (ph2_reg <= HALF_PHASE);

    always_comb begin
        unique case (waveform_reg)
            WAVE_SINE: begin
                if (p_out[31]) begin
                    wave_wide = -$signed({3'b0, tab_rd_data});
                end else begin
                    wave_wide = $signed({3'b0, tab_rd_data});
                end
            end
            WAVE_SQUARE: begin
                wave_wide = first_half ? 19'sd32767 : -19'sd32768;
            end
            WAVE_SAW_DOWN: begin
                wave_wide = 19'sd32768 - $signed({3'b0, p_out[31:16]});
            end
            WAVE_SAW_UP: begin
                wave_wide = $signed({3'b0, p_out[31:16]}) - 19'sd32768;
            end
            WAVE_TRIANGLE: begin
                if (first_half) begin
                    wave_wide = $signed({2'b0, p_out[31:15]}) - 19'sd32768;
                end else begin
                    wave_wide = 19'sd98304 - $signed({2'b0, p_out[31:15]});
                end
            end
            default: begin
                wave_wide = '0;
            end
        endcase
    end

    always_comb begin
        phase_per_hz_next = phase_per_hz_reg;
        waveform_next     = waveform_reg;
        if (cfg_wr_en) begin
            if (cfg_index == REG_PHASE_PER_HZ) begin
                phase_per_hz_next = cfg_wr_data;
            end else if (cfg_index == REG_WAVEFORM) begin
                waveform_next = cfg_wr_data[WAVE_W-1:0];
            end
        end

        v1_next       = v1_reg;
        inc1_next     = inc1_reg;
        v2_next       = v2_reg;
        ph2_next      = ph2_reg;
        phase_next    = phase_reg;
        m_valid_next  = m_valid_reg;
        m_sample_next = m_sample_reg;

        if (en1) begin
            v1_next   = s_valid && s_ready;
            inc1_next = prod_w[47 -: PHASE_BITS];
        end
        if (en2) begin
            v2_next  = v1_reg;
            ph2_next = phase_reg;
            if (v1_reg) begin
                phase_next = phase_reg + inc1_reg;
            end
        end
        if (en3) begin
            m_valid_next  = v2_reg;
            m_sample_next = sat16(wave_wide);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_per_hz_reg <= PHASE_PER_HZ_RESET;
            waveform_reg     <= WAVE_SINE;
            phase_reg        <= '0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            phase_per_hz_reg <= phase_per_hz_next;
            waveform_reg     <= waveform_next;
            phase_reg        <= phase_next;
            v1_reg           <= v1_next;
            v2_reg           <= v2_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        inc1_reg     <= inc1_next;
        ph2_reg      <= ph2_next;
        m_sample_reg <= m_sample_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

    a_phase_moves_with_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        !(v1_reg && en2) |=> $stable(phase_reg))
        else $error("phase changed without a beat leaving the first stage");

    a_empty_while_building: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> (!v1_reg && !v2_reg && !m_valid_reg))
        else $error("beat in the pipeline before the sine table was built");

    a_no_table_write_in_service: assert property (@(posedge aclk) disable iff (!aresetn)
        tab_wr.we |-> !init_done)
        else $error("sine table written after the build finished");

    a_stage_hands_to_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && en3) |=> m_valid_reg)
        else $error("beat lost between the table stage and the output");

endmodule

`default_nettype wire

// ===== src/mwo_ram.sv =====
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ============================================================================
`default_nettype none

module mwo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/mwo_sine_init.sv =====
// ============================================================================
// Quarter-wave sine table builder
// Sequencer that evaluates a Q30 Taylor series for every table entry after
// reset and writes the rounded magnitude into the table RAM.
// ============================================================================
`default_nettype none

module mwo_sine_init
    import mwo_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    output tab_wr_t tab_wr,
    output logic    init_done
);

    typedef enum logic [12:0] {
        S_XMUL  = 13'b0000000000001,
        S_XGET  = 13'b0000000000010,
        S_SQR   = 13'b0000000000100,
        S_X2GET = 13'b0000000001000,
        S_TMUL  = 13'b0000000010000,
        S_VGET  = 13'b0000000100000,
        S_QMUL  = 13'b0000001000000,
        S_QGET  = 13'b0000010000000,
        S_DMUL  = 13'b0000100000000,
        S_CORR  = 13'b0001000000000,
        S_ACC   = 13'b0010000000000,
        S_RND   = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } init_state_t;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [3:0]  LAST_TERM   = 4'd9;

    // Reciprocals floor(2^34 / d) of the series divisors d = 2n(2n+1).
    function automatic logic [31:0] recip(input logic [3:0] n);
        logic [31:0] r;
        unique case (n)
            4'd1:    r = 32'd2863311530;
            4'd2:    r = 32'd858993459;
            4'd3:    r = 32'd409044504;
            4'd4:    r = 32'd238609294;
            4'd5:    r = 32'd156180628;
            4'd6:    r = 32'd110127366;
            4'd7:    r = 32'd81808900;
            4'd8:    r = 32'd63161283;
            4'd9:    r = 32'd50233535;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] divisor(input logic [3:0] n);
        logic [8:0] d;
        unique case (n)
            4'd1:    d = 9'd6;
            4'd2:    d = 9'd20;
            4'd3:    d = 9'd42;
            4'd4:    d = 9'd72;
            4'd5:    d = 9'd110;
            4'd6:    d = 9'd156;
            4'd7:    d = 9'd210;
            4'd8:    d = 9'd272;
            4'd9:    d = 9'd342;
            default: d = 9'd1;
        endcase
        return d;
    endfunction

    init_state_t         state_reg, state_next;
    logic [TAB_AW-1:0]   k_reg, k_next;
    logic [3:0]          n_reg, n_next;
    logic [31:0]         x_reg, x_next;
    logic [31:0]         x2_reg, x2_next;
    logic [31:0]         term_reg, term_next;
    logic [31:0]         q_reg, q_next;
    logic [32:0]         v_reg, v_next;
    logic signed [32:0]  sum_reg, sum_next;
    logic [65:0]         prod_reg, prod_next;
    logic [33:0]         rem;
    logic [31:0]         rnd;
    logic [16:0]         mag;

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        x_next     = x_reg;
        x2_next    = x2_reg;
        term_next  = term_reg;
        q_next     = q_reg;
        v_next     = v_reg;
        sum_next   = sum_reg;
        prod_next  = prod_reg;
        rem        = 34'(v_reg) - prod_reg[33:0];
        rnd        = sum_reg[31:0] + 32'd16384;
        mag        = rnd[31:15];
        unique case (state_reg)
            S_XMUL: begin
                prod_next  = 66'(HALF_PI_Q30) * 66'(k_reg);
                state_next = S_XGET;
            end
            S_XGET: begin
                x_next     = prod_reg[SINE_TABLE_BITS +: 32];
                state_next = S_SQR;
            end
            S_SQR: begin
                prod_next  = 66'(x_reg) * 66'(x_reg);
                term_next  = x_reg;
                sum_next   = $signed({1'b0, x_reg});
                n_next     = 4'd1;
                state_next = S_X2GET;
            end
            S_X2GET: begin
                x2_next    = prod_reg[30 +: 32];
                state_next = S_TMUL;
            end
            S_TMUL: begin
                prod_next  = 66'(term_reg) * 66'(x2_reg);
                state_next = S_VGET;
            end
            S_VGET: begin
                v_next     = prod_reg[30 +: 33];
                state_next = S_QMUL;
            end
            S_QMUL: begin
                prod_next  = 66'(v_reg) * 66'(recip(n_reg));
                state_next = S_QGET;
            end
            S_QGET: begin
                q_next     = prod_reg[34 +: 32];
                state_next = S_DMUL;
            end
            S_DMUL: begin
                prod_next  = 66'(q_reg) * 66'(divisor(n_reg));
                state_next = S_CORR;
            end
            S_CORR: begin
                term_next  = (rem >= 34'(divisor(n_reg))) ? q_reg + 32'd1 : q_reg;
                state_next = S_ACC;
            end
            S_ACC: begin
                if (n_reg[0]) begin
                    sum_next = sum_reg - $signed({1'b0, term_reg});
                end else begin
                    sum_next = sum_reg + $signed({1'b0, term_reg});
                end
                if (n_reg == LAST_TERM) begin
                    state_next = S_RND;
                end else begin
                    n_next     = n_reg + 4'd1;
                    state_next = S_TMUL;
                end
            end
            S_RND: begin
                k_next     = k_reg + TAB_AW'(1);
                state_next = (k_reg == TAB_AW'(QTAB_N)) ? S_DONE : S_XMUL;
            end
            S_DONE: begin
                state_next = S_DONE;
            end
            default: begin
                state_next = S_XMUL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_XMUL;
            k_reg     <= '0;
            n_reg     <= 4'd1;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        x2_reg   <= x2_next;
        term_reg <= term_next;
        q_reg    <= q_next;
        v_reg    <= v_next;
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
    end

    always_comb begin
        tab_wr.we   = (state_reg == S_RND);
        tab_wr.addr = k_reg;
        if (sum_reg[32]) begin
            tab_wr.data = '0;
        end else if (mag > 17'd32767) begin
            tab_wr.data = 16'd32767;
        end else begin
            tab_wr.data = mag[SAMPLE_W-1:0];
        end
    end

    assign init_done = (state_reg == S_DONE);

    a_term_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ACC) |-> (n_reg >= 4'd1 && n_reg <= LAST_TERM))
        else $error("series term index out of range");

    a_write_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        tab_wr.we |=> (k_reg == $past(k_reg) + TAB_AW'(1)))
        else $error("table address did not advance after a write");

endmodule

`default_nettype wire
